>>> hw/rtl/q24alu_pkg.sv
// ----------------------------------------------------------------------------
// q24alu_pkg
// Operation codes, internal item classes and the front-to-back queue item.
// ----------------------------------------------------------------------------
package q24alu_pkg;

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_GT       = 4'd4,
        ACT_GE       = 4'd5,
        ACT_LT       = 4'd6,
        ACT_LE       = 4'd7,
        ACT_EQ       = 4'd8,
        ACT_NE       = 4'd9,
        ACT_MIN      = 4'd10,
        ACT_MAX      = 4'd11,
        ACT_INC      = 4'd12,
        ACT_DEC      = 4'd13,
        ACT_TO_INT   = 4'd14,
        ACT_FROM_INT = 4'd15
    } t_action;

    // how the back end has to finish an item
    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] result;
        logic               cmp;
        logic               dz;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_item;

endpackage

>>> hw/rtl/q24alu_if.sv
// ----------------------------------------------------------------------------
// q24alu channel interfaces
// Operation channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface q24alu_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, action, operand_a, operand_b, input ready);
    modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface q24alu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;

    modport source (output valid, result_value, compare_true, divide_by_zero,
                    input ready);
    modport sink   (input valid, result_value, compare_true, divide_by_zero,
                    output ready);
endinterface

>>> hw/rtl/q24_8_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu
// Signed fixed-point arithmetic unit, one result per operation.
//
//   channel  dir  payload
//   i_in     in   action, operand_a, operand_b
//   o_out    out  result_value, compare_true, divide_by_zero
//
// One operation per cycle sustained while the output is not stalled. Path:
// front register, queue, product stage, 32 + FRACTION_BITS divider stages
// (one quotient bit each) and the output register.
// Every operation takes the same path, so results leave in order.
// A stalled output freezes the back end; the queue lets the front keep
// taking beats until it fills. Reset is synchronous and clears all valids.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu
    import q24alu_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    q24alu_in_if.sink     i_in,
    q24alu_out_if.source  o_out
);
    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    q24alu_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    q24alu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    q24alu_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_out   (o_out)
    );
endmodule

>>> hw/rtl/q24alu_front.sv
// ----------------------------------------------------------------------------
// q24alu_front
// Accepts operations, finishes the simple ones and tags multiply and divide.
// ----------------------------------------------------------------------------
module q24alu_front
    import q24alu_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    q24alu_in_if.sink      i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output t_item          o_item
);
    localparam logic [31:0] LowMask = 32'((64'd1 << FRACTION_BITS) - 64'd1);

    logic               r_valid;
    t_item              r_item;
    t_item              n_item;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] biased;
    logic               lt;

    assign a  = i_in.operand_a;
    assign b  = i_in.operand_b;
    assign lt = a < b;
    // truncation toward zero: bias negatives before the arithmetic shift
    assign biased = a + (a[31] ? LowMask : 32'd0);

    always_comb begin
        n_item        = '0;
        n_item.kind   = KIND_SIMPLE;
        n_item.a      = a;
        n_item.b      = b;
        unique case (t_action'(i_in.action))
            ACT_ADD:      n_item.result = a + b;
            ACT_SUB:      n_item.result = a - b;
            ACT_MUL:      n_item.kind   = KIND_MUL;
            ACT_DIV: begin
                n_item.kind = KIND_DIV;
                n_item.dz   = (b == 32'sd0);
            end
            ACT_GT:       n_item.cmp    = !lt && (a != b);
            ACT_GE:       n_item.cmp    = !lt;
            ACT_LT:       n_item.cmp    = lt;
            ACT_LE:       n_item.cmp    = lt || (a == b);
            ACT_EQ:       n_item.cmp    = (a == b);
            ACT_NE:       n_item.cmp    = (a != b);
            ACT_MIN:      n_item.result = lt ? a : b;
            ACT_MAX:      n_item.result = lt ? b : a;
            ACT_INC:      n_item.result = a + 32'sd1;
            ACT_DEC:      n_item.result = a - 32'sd1;
            ACT_TO_INT:   n_item.result = biased >>> FRACTION_BITS;
            ACT_FROM_INT: n_item.result = a << FRACTION_BITS;
            default:      n_item.result = '0;
        endcase
    end

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_item <= n_item;
        end
    end
endmodule

>>> hw/rtl/q24alu_queue.sv
// ----------------------------------------------------------------------------
// q24alu_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module q24alu_queue
    import q24alu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule

>>> hw/rtl/q24alu_back.sv
// ----------------------------------------------------------------------------
// q24alu_back
// Back-end pipeline for all items: product stage, one quotient bit per stage,
// then sign and rounding fix-up into the output register; simple results pass.
// ----------------------------------------------------------------------------
module q24alu_back
    import q24alu_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    q24alu_out_if.source o_out
);
    localparam int          DW     = 32 + FRACTION_BITS;
    localparam logic [63:0] Bias64 = (64'd1 << FRACTION_BITS) - 64'd1;

    logic               r_v    [DW+1];
    t_kind              r_kind [DW+1];
    logic signed [31:0] r_res  [DW+1];
    logic               r_cmp  [DW+1];
    logic               r_dz   [DW+1];
    logic               r_neg  [DW+1];
    logic signed [63:0] r_prod [DW+1];
    logic [31:0]        r_rem  [DW+1];
    logic [DW-1:0]      r_dvd  [DW+1];
    logic [31:0]        r_dvs  [DW+1];

    logic               r_ov;
    logic signed [31:0] r_ores;
    logic               r_ocmp;
    logic               r_odz;

    logic               adv;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    logic signed [63:0] prod;
    logic signed [63:0] pbias;
    logic [31:0]        quo;
    logic signed [31:0] n_ores;

    assign adv     = !r_ov || o_out.ready;
    assign o_ready = adv;

    assign abs_a = i_item.a[31] ? 32'(-i_item.a) : 32'(i_item.a);
    assign abs_b = i_item.b[31] ? 32'(-i_item.b) : 32'(i_item.b);
    assign prod  = i_item.a * i_item.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
        end
        if (adv) begin
            r_kind[0] <= i_item.kind;
            r_res[0]  <= i_item.result;
            r_cmp[0]  <= i_item.cmp;
            r_dz[0]   <= i_item.dz;
            r_neg[0]  <= i_item.a[31] ^ i_item.b[31];
            r_prod[0] <= prod;
            r_rem[0]  <= '0;
            r_dvd[0]  <= {abs_a, FRACTION_BITS'(0)};
            r_dvs[0]  <= abs_b;
        end
    end

    // restoring division, quotient bits shift into the dividend register
    for (genvar s = 1; s <= DW; s++) begin : g_div
        logic [32:0] trial;
        logic [32:0] diff;
        logic        qbit;

        assign trial = {r_rem[s-1], r_dvd[s-1][DW-1]};
        assign diff  = trial - {1'b0, r_dvs[s-1]};
        assign qbit  = !diff[32];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (adv) begin
                r_v[s] <= r_v[s-1];
            end
            if (adv) begin
                r_kind[s] <= r_kind[s-1];
                r_res[s]  <= r_res[s-1];
                r_cmp[s]  <= r_cmp[s-1];
                r_dz[s]   <= r_dz[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_prod[s] <= r_prod[s-1];
                r_rem[s]  <= qbit ? diff[31:0] : trial[31:0];
                r_dvd[s]  <= {r_dvd[s-1][DW-2:0], qbit};
                r_dvs[s]  <= r_dvs[s-1];
            end
        end
    end

    assign pbias = r_prod[DW] + (r_prod[DW][63] ? Bias64 : 64'd0);
    assign quo   = r_dvd[DW][31:0];

    always_comb begin
        case (r_kind[DW])
            KIND_SIMPLE: n_ores = r_res[DW];
            KIND_MUL:    n_ores = 32'(pbias >>> FRACTION_BITS);
            KIND_DIV:    n_ores = r_dz[DW] ? 32'sd0 :
                                  (r_neg[DW] ? $signed(-quo) : $signed(quo));
            default:     n_ores = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v[DW];
        end
        if (adv) begin
            r_ores <= n_ores;
            r_ocmp <= r_cmp[DW];
            r_odz  <= r_dz[DW];
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.result_value   = r_ores;
    assign o_out.compare_true   = r_ocmp;
    assign o_out.divide_by_zero = r_odz;
endmodule
